### rtl/script_tokenizer_core_macros.svh
// Assertion macros for the tokenizer RTL.
`ifndef SCRIPT_TOKENIZER_CORE_MACROS_SVH
`define SCRIPT_TOKENIZER_CORE_MACROS_SVH

// Implication in the same cycle.
`define STC_ASSERT_HOLDS(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle.
`define STC_ASSERT_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/stc_pkg.sv
// Types, constants and keyword table of the script tokenizer.
package stc_pkg;

   localparam int LOOKAHEAD_DEPTH = 8;
   localparam int WIN_CNT_W       = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam int PAT_COUNT       = 36;
   localparam int PAT_MAX_LEN     = 7;
   localparam int PAT_SEL_W       = $clog2(PAT_COUNT);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] K_EOF     = 6'd0;
   localparam logic [5:0] K_NEWLINE = 6'd1;
   localparam logic [5:0] K_STRING  = 6'd2;
   localparam logic [5:0] K_NUMBER  = 6'd3;
   localparam logic [5:0] K_IDENT   = 6'd38;
   localparam logic [5:0] K_ERROR   = 6'd39;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
   localparam logic [1:0] ERR_SECOND_DOT = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   localparam logic [PAT_MAX_LEN*8-1:0] PAT_TEXT [PAT_COUNT] = '{
      ";", "var", "if", "else", "print", "while", "func", ":", "Number",
      "Boolean", "Bool", "String", "type", "return",
      "+", "-", "*", "/", "%", "(", ")", "{", "}",
      "&&", "||", "^^", "true", "false", "==", "!=", "!", "=", "<=", ">=",
      "<", ">"
   };

   localparam logic [2:0] PAT_LEN [PAT_COUNT] = '{
      3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd4, 3'd1, 3'd6,
      3'd7, 3'd4, 3'd6, 3'd4, 3'd6,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd4, 3'd5, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2,
      3'd1, 3'd1
   };

   localparam logic [5:0] PAT_KIND [PAT_COUNT] = '{
      6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12,
      6'd13, 6'd13, 6'd14, 6'd15, 6'd16,
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd26, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
      6'd36, 6'd37
   };

   typedef struct packed {
      logic [7:0] code;
      logic       is_end;
      logic       is_space;
      logic       is_num;
      logic       is_ident;
      logic       is_newline;
   } char_info_type;

   typedef struct packed {
      logic          valid;
      char_info_type info;
   } queue_head_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  err;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } result_type;

   function automatic logic [7:0] pat_char(input int p, input int k);
      int base;
      base = 0;
      pat_char = 8'h00;
      if (k < int'(PAT_LEN[p])) begin
         base = (int'(PAT_LEN[p]) - 1 - k) * 8;
         pat_char = PAT_TEXT[p][base +: 8];
      end
   endfunction

endpackage

### rtl/stc_channels.sv
// Handshake channel interfaces for characters in and tokens out.
interface stc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface stc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [1:0]  error_code;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [15:0] token_line;
   logic [15:0] token_column;
   logic        last_of_run;
   modport source (output valid, output token_kind, output error_code, output token_start,
                   output token_length, output token_line, output token_column,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input error_code, input token_start,
                 input token_length, input token_line, input token_column,
                 input last_of_run, output ready);
endinterface

### rtl/stc_front.sv
// Front end: character classification and input queue.
module stc_front (
   input  logic                    clock,
   input  logic                    reset,
   stc_req_if.sink                 req_if,
   output stc_pkg::queue_head_type head,
   input  logic                    head_pop
);

   stc_pkg::char_info_type       q_mem [stc_pkg::QUEUE_DEPTH];
   logic [stc_pkg::QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [stc_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   stc_pkg::char_info_type       cls;
   logic                         push, pop;
   logic [7:0]                   c;

   assign c = req_if.char_code;

   always_comb begin
      cls.code       = c;
      cls.is_end     = (c == stc_pkg::CH_END);
      cls.is_space   = (c == stc_pkg::CH_SPACE) || (c == stc_pkg::CH_TAB);
      cls.is_num     = (c >= "0" && c <= "9") || (c == stc_pkg::CH_DOT);
      cls.is_ident   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                       (c >= "0" && c <= "9") || (c == stc_pkg::CH_DASH) ||
                       (c == stc_pkg::CH_USCORE);
      cls.is_newline = (c == stc_pkg::CH_NL);
   end

   assign req_if.ready = (cnt_ff < stc_pkg::QCNT_W'(stc_pkg::QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = head_pop && (cnt_ff != '0);
   assign head.valid   = (cnt_ff != '0);
   assign head.info    = q_mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + stc_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + stc_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + stc_pkg::QCNT_W'(push) - stc_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= cls;
      end
   end

endmodule

### rtl/stc_back.sv
// Back end: lookahead window, scanner step and token output register.
module stc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  stc_pkg::queue_head_type head,
   output logic                    head_pop,
   stc_rsp_if.source               rsp_if
);

`include "script_tokenizer_core_macros.svh"

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_STRING  = 3'd2,
      MODE_NUMBER  = 3'd3,
      MODE_IDENT   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      SRC_HERE,
      SRC_BEGUN,
      SRC_BEGUN_POP
   } src_type;

   stc_pkg::char_info_type           win_ff [stc_pkg::LOOKAHEAD_DEPTH];
   stc_pkg::char_info_type           win_in [stc_pkg::LOOKAHEAD_DEPTH];
   logic [stc_pkg::WIN_CNT_W-1:0]    cnt_ff, cnt_in;
   mode_type                         mode_ff, mode_in;
   logic                             sd_ff, sd_in;
   logic [15:0]                      pos_ff, pos_in, line_ff, line_in, col_ff, col_in;
   logic [15:0]                      tb_ff, tb_in, bl_ff, bl_in, bc_ff, bc_in;
   logic                             ended_ff, ended_in;
   logic                             busy_ff, busy_in, flush_ff, flush_in;
   logic                             pend_v_ff, pend_v_in, out_v_ff, out_v_in;
   stc_pkg::result_type              pend_ff, pend_in, out_ff, out_in;

   logic [stc_pkg::PAT_COUNT-1:0]    pat_cand;
   logic                             pat_found, pat_full;
   logic [stc_pkg::PAT_SEL_W-1:0]    pat_sel;

   logic                             act_done, act_emit, act_mark, act_tb_pop, act_in_str;
   logic [5:0]                       act_kind;
   logic [1:0]                       act_err;
   src_type                          act_src;
   logic [2:0]                       act_pop;
   logic [15:0]                      act_len;
   mode_type                         act_mode;
   logic                             act_sd;

   logic [16:0]                      pos_sum, col_sum;
   logic [15:0]                      pos_pop, line_pop, col_pop;
   logic                             nl_pop;
   stc_pkg::result_type              new_res;
   logic                             out_free, need_push, do_append;
   stc_pkg::char_info_type           w0;

   assign w0 = win_ff[0];

   // keyword and operator prefix match, first candidate wins
   always_comb begin
      for (int p = 0; p < stc_pkg::PAT_COUNT; p++) begin
         pat_cand[p] = 1'b1;
         for (int k = 0; k < stc_pkg::PAT_MAX_LEN; k++) begin
            if (stc_pkg::WIN_CNT_W'(k) < cnt_ff && 3'(k) < stc_pkg::PAT_LEN[p] &&
                win_ff[k].code != stc_pkg::pat_char(p, k)) begin
               pat_cand[p] = 1'b0;
            end
         end
         if (!(cnt_ff >= stc_pkg::WIN_CNT_W'(stc_pkg::PAT_LEN[p])) && ended_ff) begin
            pat_cand[p] = 1'b0;
         end
      end
      pat_found = 1'b0;
      pat_sel   = '0;
      for (int p = stc_pkg::PAT_COUNT - 1; p >= 0; p--) begin
         if (pat_cand[p]) begin
            pat_found = 1'b1;
            pat_sel   = stc_pkg::PAT_SEL_W'(p);
         end
      end
      pat_full = (cnt_ff >= stc_pkg::WIN_CNT_W'(stc_pkg::PAT_LEN[pat_sel]));
   end

   // one scanner step
   always_comb begin
      act_done   = 1'b0;
      act_emit   = 1'b0;
      act_mark   = 1'b0;
      act_tb_pop = 1'b0;
      act_in_str = 1'b0;
      act_kind   = stc_pkg::K_EOF;
      act_err    = stc_pkg::ERR_NONE;
      act_src    = SRC_HERE;
      act_pop    = 3'd0;
      act_len    = 16'd0;
      act_mode   = mode_ff;
      act_sd     = sd_ff;
      if (mode_ff != MODE_IDLE) begin
         if (cnt_ff == '0) begin
            if (!ended_ff) begin
               act_done = 1'b1;
            end else begin
               act_mode = MODE_IDLE;
               act_src  = SRC_BEGUN;
               unique case (mode_ff)
                  MODE_STRING: begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_ERROR;
                     act_err  = stc_pkg::ERR_UNTERM_STR;
                  end
                  MODE_NUMBER: begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_NUMBER;
                  end
                  MODE_IDENT: begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_IDENT;
                  end
                  default: ;
               endcase
            end
         end else begin
            unique case (mode_ff)
               MODE_COMMENT: begin
                  act_pop = 3'd1;
                  if (w0.is_newline) begin
                     act_mode = MODE_IDLE;
                  end
               end
               MODE_STRING: begin
                  act_pop = 3'd1;
                  if (w0.code == stc_pkg::CH_QUOTE) begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_STRING;
                     act_src  = SRC_BEGUN;
                     act_mode = MODE_IDLE;
                  end else begin
                     act_in_str = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (w0.code == stc_pkg::CH_DOT && sd_ff) begin
                     act_pop  = 3'd1;
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_ERROR;
                     act_err  = stc_pkg::ERR_SECOND_DOT;
                     act_src  = SRC_BEGUN_POP;
                     act_mode = MODE_IDLE;
                  end else if (w0.is_num) begin
                     act_pop = 3'd1;
                     if (w0.code == stc_pkg::CH_DOT) begin
                        act_sd = 1'b1;
                     end
                  end else begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_NUMBER;
                     act_src  = SRC_BEGUN;
                     act_mode = MODE_IDLE;
                  end
               end
               MODE_IDENT: begin
                  if (w0.is_ident) begin
                     act_pop = 3'd1;
                  end else begin
                     act_emit = 1'b1;
                     act_kind = stc_pkg::K_IDENT;
                     act_src  = SRC_BEGUN;
                     act_mode = MODE_IDLE;
                  end
               end
               default: ;
            endcase
         end
      end else if (cnt_ff == '0) begin
         act_done = 1'b1;
         act_emit = ended_ff;
      end else if (w0.is_space) begin
         act_pop = 3'd1;
      end else if (w0.code == stc_pkg::CH_HASH) begin
         act_mode = MODE_COMMENT;
         act_pop  = 3'd1;
      end else if (w0.code == stc_pkg::CH_SLASH && cnt_ff < stc_pkg::WIN_CNT_W'(2) &&
                   !ended_ff) begin
         act_done = 1'b1;
      end else if (w0.code == stc_pkg::CH_SLASH && cnt_ff >= stc_pkg::WIN_CNT_W'(2) &&
                   win_ff[1].code == stc_pkg::CH_SLASH) begin
         act_mode = MODE_COMMENT;
         act_pop  = 3'd1;
      end else if (w0.is_newline) begin
         act_emit = 1'b1;
         act_kind = stc_pkg::K_NEWLINE;
         act_pop  = 3'd1;
      end else if (w0.code == stc_pkg::CH_QUOTE) begin
         act_mark   = 1'b1;
         act_tb_pop = 1'b1;
         act_pop    = 3'd1;
         act_mode   = MODE_STRING;
      end else if (w0.is_num) begin
         act_mark = 1'b1;
         act_sd   = 1'b0;
         act_mode = MODE_NUMBER;
      end else if (pat_found) begin
         if (!pat_full) begin
            act_done = 1'b1;
         end else begin
            act_emit = 1'b1;
            act_kind = stc_pkg::PAT_KIND[pat_sel];
            act_len  = 16'(stc_pkg::PAT_LEN[pat_sel]);
            act_pop  = stc_pkg::PAT_LEN[pat_sel];
         end
      end else if (w0.is_ident) begin
         act_mark = 1'b1;
         act_mode = MODE_IDENT;
      end else begin
         act_emit = 1'b1;
         act_kind = stc_pkg::K_ERROR;
         act_err  = stc_pkg::ERR_UNEXPECTED;
         act_len  = 16'd1;
         act_pop  = 3'd1;
      end
   end

   // position counters after the step, saturating
   always_comb begin
      pos_sum  = {1'b0, pos_ff} + 17'(act_pop);
      col_sum  = {1'b0, col_ff} + 17'(act_pop);
      pos_pop  = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
      nl_pop   = (act_pop == 3'd1) && w0.is_newline && !act_in_str;
      line_pop = (nl_pop && line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;
      col_pop  = nl_pop ? 16'd0 : (col_sum[16] ? 16'hFFFF : col_sum[15:0]);
   end

   always_comb begin
      new_res.kind = act_kind;
      new_res.err  = act_err;
      new_res.last = 1'b0;
      case (act_src)
         SRC_BEGUN: begin
            new_res.start  = tb_ff;
            new_res.length = pos_ff - tb_ff;
            new_res.line   = bl_ff;
            new_res.column = bc_ff;
         end
         SRC_BEGUN_POP: begin
            new_res.start  = tb_ff;
            new_res.length = pos_pop - tb_ff;
            new_res.line   = bl_ff;
            new_res.column = bc_ff;
         end
         default: begin
            new_res.start  = pos_ff;
            new_res.length = act_len;
            new_res.line   = line_ff;
            new_res.column = col_ff;
         end
      endcase
   end

   assign out_free  = !out_v_ff || rsp_if.ready;
   assign need_push = (act_emit && pend_v_ff) || (act_done && (pend_v_ff || act_emit));

   always_comb begin
      for (int i = 0; i < stc_pkg::LOOKAHEAD_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      sd_in     = sd_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tb_in     = tb_ff;
      bl_in     = bl_ff;
      bc_in     = bc_ff;
      ended_in  = ended_ff;
      busy_in   = busy_ff;
      flush_in  = flush_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = out_v_ff && !rsp_if.ready;
      out_in    = out_ff;
      do_append = 1'b0;
      head_pop  = 1'b0;

      if (flush_ff) begin
         if (out_free) begin
            out_v_in      = 1'b1;
            out_in        = pend_ff;
            out_in.last   = 1'b1;
            pend_v_in     = 1'b0;
            flush_in      = 1'b0;
            busy_in       = 1'b0;
         end
      end else if (busy_ff) begin
         if (!need_push || out_free) begin
            for (int i = 0; i < stc_pkg::LOOKAHEAD_DEPTH; i++) begin
               if (i + int'(act_pop) < stc_pkg::LOOKAHEAD_DEPTH) begin
                  win_in[i] = win_ff[i + int'(act_pop)];
               end
            end
            cnt_in  = cnt_ff - stc_pkg::WIN_CNT_W'(act_pop);
            mode_in = act_mode;
            sd_in   = act_sd;
            pos_in  = pos_pop;
            line_in = line_pop;
            col_in  = col_pop;
            if (act_mark) begin
               tb_in = act_tb_pop ? pos_pop : pos_ff;
               bl_in = line_ff;
               bc_in = col_ff;
            end
            if (act_done) begin
               if (act_emit && pend_v_ff) begin
                  out_v_in  = 1'b1;
                  out_in    = pend_ff;
                  pend_in   = new_res;
                  flush_in  = 1'b1;
               end else begin
                  if (act_emit) begin
                     out_v_in    = 1'b1;
                     out_in      = new_res;
                     out_in.last = 1'b1;
                  end else if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_in      = pend_ff;
                     out_in.last = 1'b1;
                     pend_v_in   = 1'b0;
                  end
                  do_append = head.valid;
                  busy_in   = head.valid;
               end
            end else if (act_emit) begin
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_in   = pend_ff;
               end
               pend_in   = new_res;
               pend_v_in = 1'b1;
            end
         end
      end else if (head.valid) begin
         do_append = 1'b1;
         busy_in   = 1'b1;
      end

      if (do_append) begin
         head_pop = 1'b1;
         if (!ended_ff) begin
            if (head.info.is_end) begin
               ended_in = 1'b1;
            end else if (cnt_ff < stc_pkg::WIN_CNT_W'(stc_pkg::LOOKAHEAD_DEPTH)) begin
               for (int i = 0; i < stc_pkg::LOOKAHEAD_DEPTH; i++) begin
                  if (stc_pkg::WIN_CNT_W'(i) == cnt_ff) begin
                     win_in[i] = head.info;
                  end
               end
               cnt_in = cnt_ff + stc_pkg::WIN_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         mode_ff   <= MODE_IDLE;
         sd_ff     <= 1'b0;
         pos_ff    <= '0;
         line_ff   <= '0;
         col_ff    <= '0;
         tb_ff     <= '0;
         bl_ff     <= '0;
         bc_ff     <= '0;
         ended_ff  <= 1'b0;
         busy_ff   <= 1'b0;
         flush_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         mode_ff   <= mode_in;
         sd_ff     <= sd_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tb_ff     <= tb_in;
         bl_ff     <= bl_in;
         bc_ff     <= bc_in;
         ended_ff  <= ended_in;
         busy_ff   <= busy_in;
         flush_ff  <= flush_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < stc_pkg::LOOKAHEAD_DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.token_kind   = out_ff.kind;
   assign rsp_if.error_code   = out_ff.err;
   assign rsp_if.token_start  = out_ff.start;
   assign rsp_if.token_length = out_ff.length;
   assign rsp_if.token_line   = out_ff.line;
   assign rsp_if.token_column = out_ff.column;
   assign rsp_if.last_of_run  = out_ff.last;

   `STC_ASSERT_HOLDS(a_idle_no_pending, reset, !busy_ff && !flush_ff, !pend_v_ff,
      "held token outside a run")
   `STC_ASSERT_HOLDS(a_flush_has_pending, reset, flush_ff, pend_v_ff,
      "flush without a held token")
   `STC_ASSERT_HOLDS(a_idle_token_open, reset, !busy_ff, mode_ff == MODE_IDLE || cnt_ff == '0,
      "open token with characters left in window")
   `STC_ASSERT_NEXT(a_flush_drains, reset, flush_ff && (!out_v_ff || rsp_if.ready),
      !flush_ff && !pend_v_ff, "flush did not complete")

endmodule

### rtl/script_tokenizer_core.sv
// Script tokenizer top level: character queue feeding the scanner back end.
// A character passes through the queue and the lookahead window before the token it ends is registered.
// Throughput: one scanner step per cycle, held while the output register is full; a character
// enters the window only when idle or in the step that closes a run, never in mid-run.
// A four-entry character queue and a one-token output register decouple the two sides.
// Reset is synchronous and clears queue, scanner state and output; no clearing pass.
module script_tokenizer_core (
   input logic       clock,
   input logic       reset,
   stc_req_if.sink   req_if,
   stc_rsp_if.source rsp_if
);

   stc_pkg::queue_head_type head;
   logic                    head_pop;

   stc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .head     (head),
      .head_pop (head_pop)
   );

   stc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .rsp_if   (rsp_if)
   );

endmodule

### tb/sv/script_tokenizer_core_tb.sv
// Testbench for the script tokenizer: random character streams checked against a token predictor.
`timescale 1ns / 100ps

module script_tokenizer_core_tb;

   typedef enum int {SCAN_IDLE, SCAN_COMMENT, SCAN_STRING, SCAN_NUMBER, SCAN_IDENT} scan_type;
   typedef enum int {NEED_MORE, PROGRESS, ENDED} dispatch_type;

   localparam int POS_LIMIT   = 65535;
   localparam int MAX_TOKENS  = 9;
   localparam int IDLE_LIMIT  = 4000;
   localparam int RANDOM_CHARS = 65;

   class token_scoreboard;
      logic [7:0]           window [stc_pkg::LOOKAHEAD_DEPTH];
      int                   window_count;
      scan_type             mode;
      bit                   seen_dot;
      int                   pos, line, col, tok_begin, tok_line, tok_col;
      bit                   ended;
      stc_pkg::result_type  step_tokens [$];
      stc_pkg::result_type  expected_tokens [$];
      int                   mismatches;

      function new();
         window_count = 0;
         mode = SCAN_IDLE;
         seen_dot = 0;
         pos = 0; line = 0; col = 0;
         tok_begin = 0; tok_line = 0; tok_col = 0;
         ended = 0;
         mismatches = 0;
      endfunction

      function void emit(logic [5:0] kind, logic [1:0] err, int start, int len, int ln, int cl);
         stc_pkg::result_type r;
         if (step_tokens.size() >= MAX_TOKENS) return;
         r.kind = kind;
         r.err = err;
         r.start = start[15:0];
         r.length = (len > 65535) ? 16'hFFFF : len[15:0];
         r.line = ln[15:0];
         r.column = cl[15:0];
         r.last = 1'b0;
         step_tokens.push_back(r);
      endfunction

      function void pop_head();
         logic [7:0] c;
         if (window_count == 0) return;
         c = window[0];
         if (pos < POS_LIMIT) pos++;
         if (c == stc_pkg::CH_NL && mode != SCAN_STRING) begin
            if (line < 65535) line++;
            col = 0;
         end else if (col < 65535) begin
            col++;
         end
         for (int i = 0; i < stc_pkg::LOOKAHEAD_DEPTH - 1; i++) window[i] = window[i + 1];
         window_count--;
      endfunction

      function void mark_begin();
         tok_begin = pos;
         tok_line = line;
         tok_col = col;
      endfunction

      function void emit_begun(logic [5:0] kind, logic [1:0] err);
         emit(kind, err, tok_begin, pos - tok_begin, tok_line, tok_col);
      endfunction

      function bit is_num(logic [7:0] c);
         return (c >= "0" && c <= "9") || c == stc_pkg::CH_DOT;
      endfunction

      function bit is_ident(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                (c >= "0" && c <= "9") || c == stc_pkg::CH_DASH || c == stc_pkg::CH_USCORE;
      endfunction

      function void scan_step(logic [7:0] c);
         case (mode)
            SCAN_COMMENT: begin
               pop_head();
               if (c == stc_pkg::CH_NL) mode = SCAN_IDLE;
            end
            SCAN_STRING: begin
               if (c == stc_pkg::CH_QUOTE) begin
                  emit_begun(stc_pkg::K_STRING, stc_pkg::ERR_NONE);
                  mode = SCAN_IDLE;
               end
               pop_head();
            end
            SCAN_NUMBER: begin
               if (c == stc_pkg::CH_DOT && seen_dot) begin
                  pop_head();
                  emit_begun(stc_pkg::K_ERROR, stc_pkg::ERR_SECOND_DOT);
                  mode = SCAN_IDLE;
               end else if (is_num(c)) begin
                  if (c == stc_pkg::CH_DOT) seen_dot = 1;
                  pop_head();
               end else begin
                  emit_begun(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE);
                  mode = SCAN_IDLE;
               end
            end
            default: begin
               if (is_ident(c)) begin
                  pop_head();
               end else begin
                  emit_begun(stc_pkg::K_IDENT, stc_pkg::ERR_NONE);
                  mode = SCAN_IDLE;
               end
            end
         endcase
      endfunction

      function void scan_close();
         if (mode == SCAN_STRING) emit_begun(stc_pkg::K_ERROR, stc_pkg::ERR_UNTERM_STR);
         else if (mode == SCAN_NUMBER) emit_begun(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE);
         else if (mode == SCAN_IDENT) emit_begun(stc_pkg::K_IDENT, stc_pkg::ERR_NONE);
         mode = SCAN_IDLE;
      endfunction

      function dispatch_type start_token();
         logic [7:0] c;
         int len, n;
         bit same;
         if (window_count == 0) begin
            if (!ended) return NEED_MORE;
            emit(stc_pkg::K_EOF, stc_pkg::ERR_NONE, pos, 0, line, col);
            return ENDED;
         end
         c = window[0];
         if (c == stc_pkg::CH_SPACE || c == stc_pkg::CH_TAB) begin
            pop_head();
            return PROGRESS;
         end
         if (c == stc_pkg::CH_HASH) begin
            mode = SCAN_COMMENT;
            pop_head();
            return PROGRESS;
         end
         if (c == stc_pkg::CH_SLASH) begin
            if (window_count < 2 && !ended) return NEED_MORE;
            if (window_count >= 2 && window[1] == stc_pkg::CH_SLASH) begin
               mode = SCAN_COMMENT;
               pop_head();
               return PROGRESS;
            end
         end
         if (c == stc_pkg::CH_NL) begin
            emit(stc_pkg::K_NEWLINE, stc_pkg::ERR_NONE, pos, 0, line, col);
            pop_head();
            return PROGRESS;
         end
         if (c == stc_pkg::CH_QUOTE) begin
            mark_begin();
            pop_head();
            tok_begin = pos;
            mode = SCAN_STRING;
            return PROGRESS;
         end
         if (is_num(c)) begin
            mark_begin();
            seen_dot = 0;
            mode = SCAN_NUMBER;
            return PROGRESS;
         end
         for (int p = 0; p < stc_pkg::PAT_COUNT; p++) begin
            len = stc_pkg::PAT_LEN[p];
            n = (window_count < len) ? window_count : len;
            same = 1;
            for (int k = 0; k < n; k++)
               if (window[k] != stc_pkg::PAT_TEXT[p][(len - 1 - k) * 8 +: 8]) same = 0;
            if (!same) continue;
            if (n < len) begin
               if (ended) continue;
               return NEED_MORE;
            end
            emit(stc_pkg::PAT_KIND[p], stc_pkg::ERR_NONE, pos, len, line, col);
            for (int k = 0; k < len; k++) pop_head();
            return PROGRESS;
         end
         if (is_ident(c)) begin
            mark_begin();
            mode = SCAN_IDENT;
            return PROGRESS;
         end
         emit(stc_pkg::K_ERROR, stc_pkg::ERR_UNEXPECTED, pos, 1, line, col);
         pop_head();
         return PROGRESS;
      endfunction

      function void note_char(logic [7:0] c);
         step_tokens.delete();
         if (!ended) begin
            if (c == stc_pkg::CH_END) ended = 1;
            else if (window_count < stc_pkg::LOOKAHEAD_DEPTH) window[window_count++] = c;
         end
         forever begin
            if (mode != SCAN_IDLE) begin
               if (window_count == 0) begin
                  if (!ended) break;
                  scan_close();
               end else begin
                  scan_step(window[0]);
               end
            end else if (start_token() != PROGRESS) begin
               break;
            end
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      endfunction

      function void check_token(stc_pkg::result_type got);
         stc_pkg::result_type want;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", got);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.err !== want.err || got.start !== want.start ||
             got.length !== want.length || got.line !== want.line ||
             got.column !== want.column || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   stc_req_if req ();
   stc_rsp_if rsp ();
   token_scoreboard tokens;
   logic [7:0] source_text [$];
   int idle_cycles;
   logic [15:0] stall_pattern;
   int pattern_age;

   script_tokenizer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      stc_pkg::result_type got;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got.kind = rsp.token_kind;
            got.err = rsp.error_code;
            got.start = rsp.token_start;
            got.length = rsp.token_length;
            got.line = rsp.token_line;
            got.column = rsp.token_column;
            got.last = rsp.last_of_run;
            tokens.check_token(got);
         end
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         if (pattern_age == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pattern <= 16'hFFFF;
               1: stall_pattern <= 16'($urandom);
               default: stall_pattern <= 16'($urandom & $urandom);
            endcase
            pattern_age <= $urandom_range(8, 64);
         end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            pattern_age <= pattern_age - 1;
         end
         rsp.ready <= stall_pattern[15];
      end else begin
         idle_cycles <= 0;
         stall_pattern <= 16'hFFFF;
         pattern_age <= 0;
         rsp.ready <= 1'b0;
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
   endtask

   task automatic add_fragment();
      int p, n;
      case ($urandom_range(0, 11)) inside
         [0:2]: begin
            p = $urandom_range(0, stc_pkg::PAT_COUNT - 1);
            for (int k = 0; k < stc_pkg::PAT_LEN[p]; k++)
               source_text.push_back(
                  stc_pkg::PAT_TEXT[p][(stc_pkg::PAT_LEN[p] - 1 - k) * 8 +: 8]);
         end
         [3:4]: begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
               case ($urandom_range(0, 4))
                  0: source_text.push_back(8'("A" + $urandom_range(0, 25)));
                  1: source_text.push_back(8'("0" + $urandom_range(0, 9)));
                  2: source_text.push_back($urandom_range(0, 1) ? stc_pkg::CH_DASH
                                                                : stc_pkg::CH_USCORE);
                  default: source_text.push_back(8'("a" + $urandom_range(0, 25)));
               endcase
         end
         5: begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
               source_text.push_back($urandom_range(0, 4) == 0 ? stc_pkg::CH_DOT
                                                               : 8'("0" + $urandom_range(0, 9)));
         end
         6: begin
            source_text.push_back(stc_pkg::CH_QUOTE);
            n = $urandom_range(0, 5);
            for (int k = 0; k < n; k++)
               source_text.push_back($urandom_range(0, 5) == 0 ? stc_pkg::CH_NL
                                                               : 8'("a" + $urandom_range(0, 25)));
            source_text.push_back(stc_pkg::CH_QUOTE);
         end
         7: begin
            if ($urandom_range(0, 1)) add_text("#");
            else add_text("//");
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) source_text.push_back(8'($urandom_range(1, 255)));
            source_text.push_back(stc_pkg::CH_NL);
            if ($urandom_range(0, 1)) source_text.push_back(stc_pkg::CH_SPACE);
         end
         8: source_text.push_back($urandom_range(0, 1) ? stc_pkg::CH_SPACE : stc_pkg::CH_TAB);
         9: source_text.push_back(stc_pkg::CH_NL);
         default: source_text.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 2) == 0) source_text.push_back(stc_pkg::CH_SPACE);
   endtask

   task automatic send_char(logic [7:0] c);
      req.valid <= 1'b1;
      req.char_code <= c;
      do @(posedge clock); while (!req.ready);
      tokens.note_char(c);
   endtask

   initial begin
      int burst;
      tokens = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.char_code = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_text("ifx-1 \"a\nb\" 1.2.3 //c\n#d\n\t@");
      source_text.push_back(8'hFF);
      source_text.push_back(8'h80);
      source_text.push_back(8'h7F);
      source_text.push_back(stc_pkg::CH_SPACE);
      while (source_text.size() < 30 + RANDOM_CHARS) add_fragment();
      case ($urandom_range(0, 3))
         0: add_text("\"open");
         1: add_text("# tail");
         2: add_text("4.2");
         default: add_text("Bool");
      endcase
      source_text.push_back(stc_pkg::CH_END);
      repeat (3) source_text.push_back(8'($urandom_range(0, 255)));

      burst = 0;
      foreach (source_text[i]) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
               req.valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         send_char(source_text[i]);
         burst--;
      end
      req.valid <= 1'b0;

      while (tokens.expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tokens.mismatches == 0 && tokens.expected_tokens.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_channels.sv
rtl/stc_front.sv
rtl/stc_back.sv
rtl/script_tokenizer_core.sv
tb/sv/script_tokenizer_core_tb.sv
